// ===== hdl/scale_packet_decoder_macros.svh =====
// Assertion macros shared by the scale packet decoder RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef SCALE_PACKET_DECODER_MACROS_SVH
`define SCALE_PACKET_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spd_pkg.sv =====
// Types and constants of the scale packet decoder.
// Depends on nothing; used by the interfaces and all modules.
`timescale 1ns / 1ps

package spd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned NibW      = 4;
  localparam int unsigned CountW    = 4;
  localparam int unsigned BitsW     = 4;
  localparam int unsigned WordW     = 16;

  localparam logic [CountW-1:0] CountMax    = 4'd12;
  localparam logic [CountW-1:0] RowBytes    = 4'd10;
  localparam logic [BitsW-1:0]  FullBits    = 4'd8;
  localparam logic [CountW-1:0] LastSumIdx  = 4'd8;
  localparam logic [CountW-1:0] WeightLoIdx = 4'd5;
  localparam logic [CountW-1:0] WeightHiIdx = 4'd6;
  localparam logic [CountW-1:0] ImpLoIdx    = 4'd7;
  localparam logic [CountW-1:0] ImpHiIdx    = 4'd8;
  localparam logic [CountW-1:0] CheckIdx    = 4'd9;
  localparam logic [NibW-1:0]   PostNibble  = 4'h9;
  localparam logic [ByteW-1:0]  PostByte    = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LENGTH    = 2'd1,
    ST_POSTAMBLE = 2'd2,
    ST_CHECKSUM  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             row_end;
    logic [BitsW-1:0] final_bits;
  } byte_item_t;

  typedef struct packed {
    status_t          status;
    logic [WordW-1:0] weight_hg;
    logic [WordW-1:0] impedance;
  } result_t;

endpackage

// ===== hdl/spd_byte_if.sv =====
// Byte channel of the scale packet decoder: valid/ready plus one raw byte.
// Depends on spd_pkg for field widths.
`timescale 1ns / 1ps

interface spd_byte_if;
  import spd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             row_end;
  logic [BitsW-1:0] final_bits;

  modport source (output valid, output data_byte, output row_end, output final_bits,
                  input ready);
  modport sink   (input valid, input data_byte, input row_end, input final_bits,
                  output ready);
endinterface

// ===== hdl/spd_result_if.sv =====
// Result channel of the scale packet decoder: valid/ready plus one row result.
// Depends on spd_pkg for field widths.
`timescale 1ns / 1ps

interface spd_result_if;
  import spd_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [WordW-1:0] weight_hg;
  logic [WordW-1:0] impedance;

  modport source (output valid, output status, output weight_hg, output impedance,
                  input ready);
  modport sink   (input valid, input status, input weight_hg, input impedance,
                  output ready);
endinterface

// ===== hdl/spd_row_acc.sv =====
// Input register and per-row accumulator of the scale packet decoder.
// Depends on spd_pkg; feeds spd_out_buf with one result per row end.
`timescale 1ns / 1ps

module spd_row_acc (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  spd_pkg::byte_item_t in_item,
  input  logic                room,
  output logic                push,
  output spd_pkg::result_t    push_result
);
  import spd_pkg::*;

  logic                item_valid;
  byte_item_t          item;
  logic                advance;
  logic [ByteW-1:0]    inv;
  logic [CountW-1:0]   byte_count;
  logic [CountW-1:0]   byte_count_next;
  logic [NibW-1:0]     nibble_sum;
  logic [NibW-1:0]     nibble_sum_next;
  logic [WordW-1:0]    weight_bytes;
  logic [WordW-1:0]    weight_bytes_next;
  logic [WordW-1:0]    impedance_bytes;
  logic [WordW-1:0]    impedance_bytes_next;
  logic [ByteW-1:0]    check_byte;
  logic [ByteW-1:0]    check_byte_next;
  logic [ByteW-1:0]    check_inv;
  result_t             result;

  // A byte that ends a row needs a free slot in the output buffer.
  assign advance  = item_valid && (!item.row_end || room);
  assign in_ready = !rst && (!item_valid || advance);
  assign inv      = ~item.data_byte;
  assign check_inv = ~check_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

  always_comb begin
    byte_count_next      = byte_count;
    nibble_sum_next      = nibble_sum;
    weight_bytes_next    = weight_bytes;
    impedance_bytes_next = impedance_bytes;
    check_byte_next      = check_byte;
    result.status        = ST_OK;
    result.weight_hg     = '0;
    result.impedance     = '0;
    if (item.row_end) begin
      if (byte_count != RowBytes || item.final_bits != FullBits) begin
        result.status = ST_LENGTH;
      end else if (check_byte[NibW-1:0] != PostNibble || item.data_byte != PostByte) begin
        result.status = ST_POSTAMBLE;
      end else if (check_inv[ByteW-1:NibW] != nibble_sum) begin
        result.status = ST_CHECKSUM;
      end else begin
        result.weight_hg = weight_bytes;
        result.impedance = impedance_bytes;
      end
      byte_count_next      = '0;
      nibble_sum_next      = '0;
      weight_bytes_next    = '0;
      impedance_bytes_next = '0;
      check_byte_next      = '0;
    end else begin
      if (byte_count <= LastSumIdx) begin
        nibble_sum_next = nibble_sum + inv[ByteW-1:NibW] + inv[NibW-1:0];
      end
      case (byte_count)
        WeightLoIdx: weight_bytes_next[ByteW-1:0]         = inv;
        WeightHiIdx: weight_bytes_next[WordW-1:ByteW]     = inv;
        ImpLoIdx:    impedance_bytes_next[ByteW-1:0]      = inv;
        ImpHiIdx:    impedance_bytes_next[WordW-1:ByteW]  = inv;
        CheckIdx:    check_byte_next                      = item.data_byte;
        default: ;
      endcase
      if (byte_count < CountMax) begin
        byte_count_next = byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      nibble_sum      <= '0;
      weight_bytes    <= '0;
      impedance_bytes <= '0;
      check_byte      <= '0;
    end else if (advance) begin
      byte_count      <= byte_count_next;
      nibble_sum      <= nibble_sum_next;
      weight_bytes    <= weight_bytes_next;
      impedance_bytes <= impedance_bytes_next;
      check_byte      <= check_byte_next;
    end
  end

  assign push        = advance && item.row_end;
  assign push_result = result;

endmodule

// ===== hdl/spd_out_buf.sv =====
// Result register with a skid slot, so the accumulator keeps moving while
// a result waits. Depends on spd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "scale_packet_decoder_macros.svh"

module spd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  spd_pkg::result_t push_result,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output spd_pkg::result_t out_result
);
  import spd_pkg::*;

  logic    skid_valid;
  result_t skid_result;
  logic    pop;

  assign pop  = out_valid && out_ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (!out_valid) begin
        out_valid <= push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_result <= skid_result;
    end else if (push && (pop || !out_valid)) begin
      out_result <= push_result;
    end
    if (push && out_valid && !pop) begin
      skid_result <= push_result;
    end
  end

  `SPD_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid full with empty output")
  `SPD_ASSERT_NOW(a_no_push_when_full, clk, rst, push, !skid_valid, "result pushed into full buffer")
  `SPD_ASSERT_NEXT(a_stall_goes_to_skid, clk, rst, push && out_valid && !out_ready, skid_valid && out_valid, "stalled result lost")
  `SPD_ASSERT_NEXT(a_skid_drains, clk, rst, pop && skid_valid, out_valid && !skid_valid, "skid slot did not drain")

endmodule

// ===== hdl/scale_packet_decoder.sv =====
// Top level of the scale packet decoder: byte channel in, row result out.
// Depends on spd_pkg, spd_byte_if, spd_result_if, spd_row_acc, spd_out_buf.
`timescale 1ns / 1ps

// The decoder takes one raw radio byte per transfer and gives one result per
// marked row end, none for other bytes. A byte moves into an input register
// and is folded into the row state from there; a row end writes its status,
// weight and impedance into the result register, or into the skid slot while
// the result register holds a result not yet taken. It sustains one byte per
// cycle while no row end waits. The only stall comes from the result side: a
// result register plus one skid slot hold finished rows, and a row-end byte
// waits only while both are full. There is no reset sweep; the block is ready once reset falls.
module scale_packet_decoder (
  input logic          clk,
  input logic          rst,
  spd_byte_if.sink     byte_ch,
  spd_result_if.source result_ch
);
  import spd_pkg::*;

  byte_item_t in_item;
  logic       room;
  logic       push;
  result_t    push_result;
  result_t    out_result;

  assign in_item.data_byte  = byte_ch.data_byte;
  assign in_item.row_end    = byte_ch.row_end;
  assign in_item.final_bits = byte_ch.final_bits;

  spd_row_acc u_row_acc (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (byte_ch.valid),
    .in_ready    (byte_ch.ready),
    .in_item     (in_item),
    .room        (room),
    .push        (push),
    .push_result (push_result)
  );

  spd_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_result (push_result),
    .room        (room),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .out_result  (out_result)
  );

  assign result_ch.status    = out_result.status;
  assign result_ch.weight_hg = out_result.weight_hg;
  assign result_ch.impedance = out_result.impedance;

endmodule

// ===== verif/tb_scale_packet_decoder.sv =====
// Testbench of the scale packet decoder: drives raw radio rows on the byte
// channel and checks every row result against an in-bench row predictor or a typed-in result.
// Depends on spd_pkg, spd_byte_if, spd_result_if and scale_packet_decoder.
`timescale 1ns / 1ps

module tb_scale_packet_decoder;
  import spd_pkg::*;

  localparam int unsigned RandomBytes   = 1620;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned ReportMax     = 10;

  typedef struct packed {
    byte_item_t item;
    logic       typed;
    result_t    res;
  } plan_row_t;

  localparam result_t NoResult = '{ST_OK, 16'h0000, 16'h0000};

  logic clk = 1'b0;
  logic rst = 1'b1;

  spd_byte_if   byte_ch ();
  spd_result_if result_ch ();

  // Side-band of the directed table: travels with each byte so that the
  // input monitor can take the typed-in result instead of the predicted one.
  logic    typed_flag = 1'b0;
  result_t typed_row  = NoResult;

  scale_packet_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  always #5 clk = ~clk;

  // Row predictor state.
  logic [CountW-1:0] row_count  = '0;
  logic [NibW-1:0]   row_sum    = '0;
  logic [WordW-1:0]  row_weight = '0;
  logic [WordW-1:0]  row_imp    = '0;
  logic [ByteW-1:0]  row_check  = '0;

  result_t     expected_rows[$];
  int unsigned fail_count   = 0;
  int unsigned sent_bytes   = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned quiet_cycles = 0;
  plan_row_t   directed_plan[$];

  // Folds one accepted byte into the row state; returns 1 with the row
  // result when the byte closes the row.
  function automatic bit decode_byte(input byte_item_t it, output result_t res);
    logic [ByteW-1:0] inv;
    logic [ByteW-1:0] inv_check;
    inv = ~it.data_byte;
    res = NoResult;
    if (!it.row_end) begin
      if (row_count <= LastSumIdx) row_sum = row_sum + inv[7:4] + inv[3:0];
      case (row_count)
        WeightLoIdx: row_weight[7:0]  = inv;
        WeightHiIdx: row_weight[15:8] = inv;
        ImpLoIdx:    row_imp[7:0]     = inv;
        ImpHiIdx:    row_imp[15:8]    = inv;
        CheckIdx:    row_check        = it.data_byte;
        default: ;
      endcase
      if (row_count < CountMax) row_count = row_count + 1'b1;
      return 1'b0;
    end
    inv_check = ~row_check;
    if (row_count != RowBytes || it.final_bits != FullBits) begin
      res.status = ST_LENGTH;
    end else if (row_check[3:0] != PostNibble || it.data_byte != PostByte) begin
      res.status = ST_POSTAMBLE;
    end else if (inv_check[7:4] != row_sum) begin
      res.status = ST_CHECKSUM;
    end else begin
      res.status    = ST_OK;
      res.weight_hg = row_weight;
      res.impedance = row_imp;
    end
    row_count  = '0;
    row_sum    = '0;
    row_weight = '0;
    row_imp    = '0;
    row_check  = '0;
    return 1'b1;
  endfunction

  function automatic plan_row_t plan(input logic [7:0] data, input logic row_end,
                                     input logic [3:0] bits, input logic typed,
                                     input status_t st, input logic [15:0] w,
                                     input logic [15:0] z);
    plan_row_t p;
    p.item  = '{data, row_end, bits};
    p.typed = typed;
    p.res   = '{st, w, z};
    return p;
  endfunction

  // Offers one byte and holds it until the transfer; valid stays high when
  // the next byte follows at once.
  task automatic send_byte(input byte_item_t it, input logic typed, input result_t res);
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= it.data_byte;
    byte_ch.row_end    <= it.row_end;
    byte_ch.final_bits <= it.final_bits;
    typed_flag         <= typed;
    typed_row          <= res;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sent_bytes++;
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Mostly well-formed rows with random content, the rest broken ones.
  task automatic send_random_row();
    logic [ByteW-1:0] row[$];
    logic [ByteW-1:0] inv;
    logic [ByteW-1:0] end_byte;
    logic [NibW-1:0]  sum;
    logic [NibW-1:0]  nib;
    logic [BitsW-1:0] bits;
    int unsigned      kind;
    int unsigned      n;
    kind = $urandom_range(99);
    sum  = '0;
    if (kind < 79) begin
      for (int i = 0; i < 9; i++) begin
        inv = 8'($urandom_range(255));
        sum = sum + inv[7:4] + inv[3:0];
        row.push_back(~inv);
      end
      row.push_back({~sum, PostNibble});
      end_byte = PostByte;
      bits     = FullBits;
      if (kind >= 55 && kind < 67) begin
        row[9][7:4] = row[9][7:4] ^ 4'($urandom_range(15, 1));
      end else if (kind >= 67) begin
        if ($urandom_range(1) == 0) begin
          nib = 4'($urandom_range(15));
          if (nib == PostNibble) nib = ~nib;
          row[9][3:0] = nib;
        end else begin
          end_byte = 8'($urandom_range(254));
        end
      end
    end else begin
      n    = (kind < 92) ? $urandom_range(13) : $urandom_range(15, 11);
      bits = 4'($urandom_range(15));
      // An eleven-byte row whose marked byte carries no bits.
      if ($urandom_range(7) == 0) begin
        n    = 10;
        bits = '0;
      end
      for (int i = 0; i < n; i++) row.push_back(8'($urandom_range(255)));
      end_byte = 8'($urandom_range(255));
    end
    foreach (row[i])
      send_byte(byte_item_t'{row[i], 1'b0, 4'($urandom_range(15))}, 1'b0, NoResult);
    send_byte(byte_item_t'{end_byte, 1'b1, bits}, 1'b0, NoResult);
  endtask

  // Input monitor: predicts the result of every row end at its transfer.
  always @(posedge clk) begin : input_monitor
    result_t res;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (decode_byte('{byte_ch.data_byte, byte_ch.row_end, byte_ch.final_bits}, res))
        expected_rows.push_back(typed_flag ? typed_row : res);
    end
  end

  // Result monitor.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_rows.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportMax)
          $display("unexpected row result: status %0d weight %h impedance %h",
                   result_ch.status, result_ch.weight_hg, result_ch.impedance);
      end else begin
        want = expected_rows.pop_front();
        if (result_ch.status !== want.status || result_ch.weight_hg !== want.weight_hg ||
            result_ch.impedance !== want.impedance) begin
          fail_count++;
          if (fail_count <= ReportMax)
            $display("row result mismatch: expected status %0d weight %h impedance %h,",
                     want.status, want.weight_hg, want.impedance,
                     " got status %0d weight %h impedance %h",
                     result_ch.status, result_ch.weight_hg, result_ch.impedance);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that fills the block.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_end;
    int unsigned rows;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = '0;
    byte_ch.row_end    = 1'b0;
    byte_ch.final_bits = '0;

    // Row ends alone, a clean row of extremes, a row that fails both the
    // postamble and the checksum, and a short row.
    directed_plan = '{
      plan(8'h00, 1'b1, 4'd0,  1'b1, ST_LENGTH, 16'h0000, 16'h0000),
      plan(8'hA5, 1'b1, 4'd15, 1'b1, ST_LENGTH, 16'h0000, 16'h0000),
      plan(8'h00, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h00, 1'b0, 4'd15, 1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h00, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h00, 1'b0, 4'd15, 1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h00, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h00, 1'b0, 4'd15, 1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h00, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h00, 1'b0, 4'd15, 1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h00, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h19, 1'b0, 4'd8,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b1, 4'd8,  1'b1, ST_OK, 16'hFFFF, 16'hFFFF),
      plan(8'hFF, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h00, 1'b0, 4'd0,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'h7E, 1'b1, 4'd8,  1'b1, ST_POSTAMBLE, 16'h0000, 16'h0000),
      plan(8'h5A, 1'b0, 4'd3,  1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hC3, 1'b0, 4'd12, 1'b0, ST_OK, 16'h0, 16'h0),
      plan(8'hFF, 1'b1, 4'd8,  1'b1, ST_LENGTH, 16'h0000, 16'h0000)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i])
      send_byte(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].res);

    rows = 0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
      endcase
      phase_end = sent_bytes + RandomBytes / 4;
      while (sent_bytes < phase_end) begin
        // The long receiver hold-off falls in the first phase, which has no sender gaps.
        if (p == 0 && rows == 8) hold_req = 1'b1;
        send_random_row();
        rows++;
      end
    end

    byte_ch.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
